[rtl/pnc_pkg.sv]
// Shared types and constants of the PN sequence correlator.
`default_nettype none
package pnc_pkg;

  localparam int DEG_BITS      = 5;
  localparam int LFSR_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_DEGREE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_MASK = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_SEED    = 2'd2;

  localparam logic [DEG_BITS-1:0]  RST_CODE_DEGREE   = 5'd10;
  localparam logic [LFSR_BITS-1:0] RST_FEEDBACK_MASK = 16'd1;
  localparam logic [LFSR_BITS-1:0] RST_START_SEED    = 16'd1;

  // queue entry kind
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    logic [DEG_BITS-1:0]  code_degree;
    logic [LFSR_BITS-1:0] feedback_mask;
    logic [LFSR_BITS-1:0] start_seed;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

[rtl/pnc_fifo.sv]
// Small register queue between the front and back halves.
`default_nettype none
module pnc_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;

  assign full       = (count_r == (AW+1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (AW+1)'(1);
        2'b01:   count_r <= count_r - (AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

[rtl/pnc_front.sv]
// Input stage: takes transactions, tags them as sample or restart, queues them.
`default_nettype none
module pnc_front import pnc_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ENTRY_W     = 1 + 2 * SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_q,
  output logic                               push,
  output logic [ENTRY_W-1:0]                 push_data,
  input  wire logic                          fifo_full
);

  logic               hold_r;
  op_t                op_r;
  logic [SAMPLE_BITS-1:0] smp_i_r;
  logic [SAMPLE_BITS-1:0] smp_q_r;
  logic               take;

  assign in_stall  = hold_r && fifo_full;
  assign take      = in_valid && !in_stall;
  assign push      = hold_r && !fifo_full;
  assign push_data = {op_r, smp_i_r, smp_q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (take) begin
      hold_r <= 1'b1;
    end else if (push) begin
      hold_r <= 1'b0;
    end
  end

  // restart entries carry no samples
  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= in_command ? OP_RESTART : OP_SAMPLE;
      smp_i_r <= in_command ? '0 : in_sample_i;
      smp_q_r <= in_command ? '0 : in_sample_q;
    end
  end

endmodule
`default_nettype wire

[rtl/pnc_div.sv]
// Bit-serial signed divider for the end-of-period quotient, I and Q in lockstep.
`default_nettype none
module pnc_div import pnc_pkg::*; #(
  parameter int ACC_W = 32,
  parameter int LEN_W = 16,
  parameter int OUT_W = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] sum_i,
  input  wire logic signed [ACC_W-1:0] sum_q,
  input  wire logic [LEN_W-1:0]        len,
  input  wire logic                    take,
  output div_status_t                  status,
  output logic signed [OUT_W-1:0]      corr_i,
  output logic signed [OUT_W-1:0]      corr_q
);

  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int STP_W = LEN_W + 1 + ACC_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [LEN_W-1:0]   den_r;
  logic               neg_i_r, neg_q_r;
  logic [ACC_W-1:0]   mag_i_r, mag_q_r;
  logic [LEN_W:0]     rem_i_r, rem_q_r;
  logic [STP_W-1:0]   stp_i, stp_q;

  // one restoring step: returns {remainder, shifted magnitude with quotient bit}
  function automatic logic [STP_W-1:0] div_step(input logic [LEN_W:0] rem,
                                                input logic [ACC_W-1:0] mag,
                                                input logic [LEN_W-1:0] den);
    logic [LEN_W:0] sh;
    logic           qb;
    sh = {rem[LEN_W-1:0], mag[ACC_W-1]};
    qb = (sh >= {1'b0, den});
    if (qb) begin
      sh = sh - {1'b0, den};
    end
    return {sh, mag[ACC_W-2:0], qb};
  endfunction

  function automatic logic [OUT_W-1:0] saturate(input logic neg, input logic [ACC_W-1:0] mag);
    logic [ACC_W-1:0] lim;
    logic [OUT_W-1:0] res;
    lim = ACC_W'(1) << (OUT_W - 1);
    if (!neg) begin
      res = (mag >= lim) ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
    end else begin
      res = (mag > lim) ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-mag[OUT_W-1:0]);
    end
    return res;
  endfunction

  assign stp_i = div_step(rem_i_r, mag_i_r, den_r);
  assign stp_q = div_step(rem_q_r, mag_q_r, den_r);

  assign status.idle = (state_r == S_IDLE);
  assign status.done = (state_r == S_DONE);
  assign corr_i = saturate(neg_i_r, mag_i_r);
  assign corr_q = saturate(neg_q_r, mag_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            cnt_r   <= CNT_W'(ACC_W);
            den_r   <= len;
            neg_i_r <= sum_i[ACC_W-1];
            neg_q_r <= sum_q[ACC_W-1];
            mag_i_r <= sum_i[ACC_W-1] ? ACC_W'(-sum_i) : ACC_W'(sum_i);
            mag_q_r <= sum_q[ACC_W-1] ? ACC_W'(-sum_q) : ACC_W'(sum_q);
            rem_i_r <= '0;
            rem_q_r <= '0;
          end
        end
        S_RUN: begin
          {rem_i_r, mag_i_r} <= stp_i;
          {rem_q_r, mag_q_r} <= stp_q;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pnc_back.sv]
// Execution stage: LFSR chip generation, restart sweep and period accumulation.
`default_nettype none
module pnc_back import pnc_pkg::*; #(
  parameter int MAX_DEGREE  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_W       = SAMPLE_BITS + MAX_DEGREE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cfg_t                          cfg,
  input  wire logic                          head_valid,
  input  wire op_t                           head_op,
  input  wire logic signed [SAMPLE_BITS-1:0] head_i,
  input  wire logic signed [SAMPLE_BITS-1:0] head_q,
  output logic                               pop,
  input  wire div_status_t                   div_status,
  output logic                               div_start,
  output logic signed [ACC_W-1:0]            div_sum_i,
  output logic signed [ACC_W-1:0]            div_sum_q,
  output logic [MAX_DEGREE-1:0]              div_len
);

  localparam int M = MAX_DEGREE;

  logic                   restart_busy_r;
  logic [M-1:0]           step_cnt_r;
  logic [LFSR_BITS-1:0]   shift_r;
  logic                   held_r;
  logic [M-1:0]           pos_r;
  logic signed [ACC_W-1:0] acc_i_r, acc_q_r;

  logic [DEG_BITS:0]      deg;
  logic [M:0]             len_wide;
  logic [M-1:0]           len;
  logic                   out_bit;
  logic [LFSR_BITS-1:0]   shift_nxt;
  logic [M:0]             pos_inc;
  logic                   is_sample, ends, chip;
  logic signed [ACC_W-1:0] si, sq, sum_i, sum_q;

  // degree clamped to [2, MAX_DEGREE]
  always_comb begin
    deg = {1'b0, cfg.code_degree};
    if (deg < (DEG_BITS+1)'(2)) begin
      deg = (DEG_BITS+1)'(2);
    end else if (deg > (DEG_BITS+1)'(M)) begin
      deg = (DEG_BITS+1)'(M);
    end
  end

  assign len_wide = ((M+1)'(1) << deg) - (M+1)'(1);
  assign len      = len_wide[M-1:0];

  // Galois step: shift right, fold taps in when the output bit is set
  assign out_bit   = shift_r[0];
  assign shift_nxt = {1'b0, shift_r[LFSR_BITS-1:1]} ^ (out_bit ? cfg.feedback_mask : '0);

  assign pos_inc   = {1'b0, pos_r} + (M+1)'(1);
  assign ends      = (pos_inc >= {1'b0, len});
  assign is_sample = (head_op == OP_SAMPLE);
  assign chip      = (pos_r != '0) ? out_bit : held_r;

  assign si = ACC_W'(head_i);
  assign sq = ACC_W'(head_q);
  assign sum_i = chip ? acc_i_r + si : acc_i_r - si;
  assign sum_q = chip ? acc_q_r + sq : acc_q_r - sq;

  assign pop = head_valid && !restart_busy_r && !(is_sample && ends && !div_status.idle);
  assign div_start = pop && is_sample && ends;
  assign div_sum_i = sum_i;
  assign div_sum_q = sum_q;
  assign div_len   = len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_busy_r <= 1'b0;
      step_cnt_r     <= '0;
      shift_r        <= '0;
      held_r         <= 1'b0;
      pos_r          <= '0;
      acc_i_r        <= '0;
      acc_q_r        <= '0;
    end else if (restart_busy_r) begin
      shift_r    <= shift_nxt;
      held_r     <= out_bit;
      step_cnt_r <= step_cnt_r - M'(1);
      if (step_cnt_r == M'(1)) begin
        restart_busy_r <= 1'b0;
      end
    end else if (pop) begin
      if (!is_sample) begin
        shift_r        <= cfg.start_seed;
        restart_busy_r <= 1'b1;
        step_cnt_r     <= len;
        pos_r          <= '0;
        acc_i_r        <= '0;
        acc_q_r        <= '0;
      end else begin
        if (pos_r != '0) begin
          shift_r <= shift_nxt;
        end
        held_r <= chip;
        if (ends) begin
          pos_r   <= '0;
          acc_i_r <= '0;
          acc_q_r <= '0;
        end else begin
          pos_r   <= pos_inc[M-1:0];
          acc_i_r <= sum_i;
          acc_q_r <= sum_q;
        end
      end
    end
  end

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    restart_busy_r |-> !pop)
    else $error("queue popped during restart sweep");

  a_launch_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> div_status.idle)
    else $error("divider launched while busy");

  a_launch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (pos_r == '0 && acc_i_r == '0 && acc_q_r == '0))
    else $error("period state not cleared after period end");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !is_sample) |=> (restart_busy_r && pos_r == '0))
    else $error("restart did not start sweep");

endmodule
`default_nettype wire

[rtl/pn_sequence_correlator.sv]
// Top level of the PN sequence correlator: config registers, queue, stages, result register.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transaction per sample. in_command = 0
//    correlates in_sample_i/in_sample_q against the next chip; in_command = 1
//    reloads the seed and sweeps the LFSR through one code period.
//  - Result channel (out_valid / out_stall): one transaction per code period of
//    L = 2^degree - 1 samples, carrying the period sums divided by L, truncated
//    toward zero and saturated.
//  - Config channel (cfg_valid / cfg_ready, cfg_ready always high): index 0 code
//    degree, 1 feedback mask, 2 start seed. Write only while the block is idle.
// Throughput: one sample per cycle unless the block stalls. A period end must wait
//  for the bit-serial divider to be idle, so short periods can slow the stream. A
//  restart holds the back stage while the LFSR steps through one code period.
// Path: a sample passes the front holding register and the queue to the back stage;
//  its result then passes the bit-serial divider and the result register.
// Reset: config returns to degree 10, mask 1, seed 1; LFSR is zero (all chips -1)
//  until the first restart. A stalled receiver holds the result register, then the
//  divider, then the queue, and finally raises in_stall.
`default_nettype none
module pn_sequence_correlator import pnc_pkg::*; #(
  parameter int MAX_DEGREE  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input samples
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_q,
  // correlation results
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_corr_i,
  output logic signed [SAMPLE_BITS-1:0]      out_corr_q,
  // configuration writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int ACC_W   = SAMPLE_BITS + MAX_DEGREE;  // exact period sum
  localparam int ENTRY_W = 1 + 2 * SAMPLE_BITS;       // {op, i, q}
  localparam int Q_DEPTH = 4;

  cfg_t                    cfg_r;
  logic                    push, fifo_full, pop, head_valid;
  logic [ENTRY_W-1:0]      push_data, head_data;
  op_t                     head_op;
  logic signed [SAMPLE_BITS-1:0] head_i, head_q;
  div_status_t             div_status;
  logic                    div_start, div_take;
  logic signed [ACC_W-1:0] div_sum_i, div_sum_q;
  logic [MAX_DEGREE-1:0]   div_len;
  logic signed [SAMPLE_BITS-1:0] div_corr_i, div_corr_q;
  logic                    out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_corr_i_r, out_corr_q_r;

  // configuration registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_degree   <= RST_CODE_DEGREE;
      cfg_r.feedback_mask <= RST_FEEDBACK_MASK;
      cfg_r.start_seed    <= RST_START_SEED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CODE_DEGREE:   cfg_r.code_degree   <= cfg_data[DEG_BITS-1:0];
        REG_FEEDBACK_MASK: cfg_r.feedback_mask <= cfg_data[LFSR_BITS-1:0];
        REG_START_SEED:    cfg_r.start_seed    <= cfg_data[LFSR_BITS-1:0];
        default:           cfg_r <= cfg_r;
      endcase
    end
  end

  pnc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_sample_i (in_sample_i),
    .in_sample_q (in_sample_q),
    .push        (push),
    .push_data   (push_data),
    .fifo_full   (fifo_full)
  );

  pnc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_op = op_t'(head_data[ENTRY_W-1]);
  assign head_i  = head_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign head_q  = head_data[SAMPLE_BITS-1:0];

  pnc_back #(
    .MAX_DEGREE  (MAX_DEGREE),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_i     (head_i),
    .head_q     (head_q),
    .pop        (pop),
    .div_status (div_status),
    .div_start  (div_start),
    .div_sum_i  (div_sum_i),
    .div_sum_q  (div_sum_q),
    .div_len    (div_len)
  );

  pnc_div #(
    .ACC_W (ACC_W),
    .LEN_W (MAX_DEGREE),
    .OUT_W (SAMPLE_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .sum_i  (div_sum_i),
    .sum_q  (div_sum_q),
    .len    (div_len),
    .take   (div_take),
    .status (div_status),
    .corr_i (div_corr_i),
    .corr_q (div_corr_q)
  );

  // result register: refills in the same cycle the old transaction leaves
  assign div_take = div_status.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_corr_i_r <= div_corr_i;
      out_corr_q_r <= div_corr_q;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_corr_i = out_corr_i_r;
  assign out_corr_q = out_corr_q_r;

endmodule
`default_nettype wire

[tb/pn_sequence_correlator_test.sv]
// Self-checking testbench for the PN sequence correlator: directed corner cases, then random traffic.
module pn_sequence_correlator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pnc_pkg::*;

  localparam int MAX_DEGREE     = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int RANDOM_ITEMS   = 500;
  // Longest quiet stretch of a correct run is a degree-16 restart plus the settle
  // wait behind it; allow several times that.
  localparam int WATCHDOG_LIMIT = 400000;
  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD} stall_mode_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] corr_i;
    logic signed [SAMPLE_BITS-1:0] corr_q;
  } corr_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_command;
  logic signed [SAMPLE_BITS-1:0] in_sample_i;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_corr_i;
  logic signed [SAMPLE_BITS-1:0] out_corr_q;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_data;

  // Correlations still owed by the block, oldest first.
  corr_t corr_expected[$];
  corr_t corr_front;
  int    mismatch_count = 0;
  int    idle_cycles    = 0;

  // Shadow of the block: config registers and code generator / integrator state.
  cfg_t                          model_cfg;
  logic [LFSR_BITS-1:0]          code_reg;
  logic                          held_chip;
  int unsigned                   chip_pos;
  longint                        sum_i;
  longint                        sum_q;
  // Rough count of cycles the block may still be busy with work that yields no result.
  int unsigned                   trailing_cycles;

  // Sender burst state.
  int unsigned                   burst_left = 0;

  pn_sequence_correlator #(
    .MAX_DEGREE (MAX_DEGREE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_sample_i(in_sample_i),
    .in_sample_q(in_sample_q),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_corr_i (out_corr_i),
    .out_corr_q (out_corr_q),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Period length; degree is clamped to [2, MAX_DEGREE].
  function automatic int unsigned code_length(logic [DEG_BITS-1:0] deg);
    int unsigned d;
    d = 32'(deg);
    if (d < 2) d = 2;
    if (d > MAX_DEGREE) d = MAX_DEGREE;
    return (1 << d) - 1;
  endfunction

  // Galois step: output is bit 0, shift right, fold taps in on a one.
  function automatic logic advance_code();
    logic out_bit;
    out_bit  = code_reg[0];
    code_reg = code_reg >> 1;
    if (out_bit) code_reg = code_reg ^ model_cfg.feedback_mask;
    return out_bit;
  endfunction

  // Period sum / L, truncated toward zero, saturated to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] scale_sum(longint sum, int unsigned len);
    longint q;
    longint hi;
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    q  = sum / longint'(len);
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    return q[SAMPLE_BITS-1:0];
  endfunction

  // Apply one accepted transaction to the shadow state; queue a result at period end.
  function automatic void correlate(op_t op, logic signed [SAMPLE_BITS-1:0] si,
                                    logic signed [SAMPLE_BITS-1:0] sq);
    int unsigned len;
    int unsigned k;
    corr_t       res;
    len = code_length(model_cfg.code_degree);
    if (op == OP_RESTART) begin
      code_reg = model_cfg.start_seed;
      for (k = 0; k < len; k++) held_chip = advance_code();
      chip_pos = 0;
      sum_i    = 0;
      sum_q    = 0;
      trailing_cycles += len;
      return;
    end
    // first sample of a period reuses the previous chip
    if (chip_pos != 0) held_chip = advance_code();
    if (held_chip) begin
      sum_i += longint'(si);
      sum_q += longint'(sq);
    end else begin
      sum_i -= longint'(si);
      sum_q -= longint'(sq);
    end
    chip_pos++;
    if (chip_pos >= len) begin
      res.corr_i = scale_sum(sum_i, len);
      res.corr_q = scale_sum(sum_q, len);
      corr_expected.push_back(res);
      chip_pos = 0;
      sum_i    = 0;
      sum_q    = 0;
      trailing_cycles = 0;
    end else begin
      trailing_cycles += 2;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input transaction; the sender runs in bursts with random gaps between them.
  task automatic send_item(op_t op, logic signed [SAMPLE_BITS-1:0] si,
                           logic signed [SAMPLE_BITS-1:0] sq);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_command  <= op;
    in_sample_i <= si;
    in_sample_q <= sq;
    do @(posedge clk); while (in_stall);
    correlate(op, si, sq);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CODE_DEGREE:   model_cfg.code_degree   = val[DEG_BITS-1:0];
      REG_FEEDBACK_MASK: model_cfg.feedback_mask = val[LFSR_BITS-1:0];
      REG_START_SEED:    model_cfg.start_seed    = val[LFSR_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for all owed results, then let in-flight work drain.
  task automatic settle();
    int unsigned tail;
    @(negedge clk);
    in_valid <= 1'b0;
    while (corr_expected.size() != 0) @(posedge clk);
    tail = 100 + trailing_cycles;
    repeat (tail) @(posedge clk);
    trailing_cycles = 0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    case ($urandom_range(0, 7))
      0: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Code generator never restarted: register is zero, every chip is -1. Reset
  // degree is 10; dropping to 2 mid-period ends the period on the next sample.
  // Four negative extremes give +131072/3, four positive ones give the other rail.
  task automatic test_before_restart();
    send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
    send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
    send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
    settle();
    write_reg(REG_CODE_DEGREE, 16'd2);
    send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
  endtask

  // Restart with reset mask and seed; samples on the restart are ignored.
  task automatic test_reset_code();
    send_item(OP_RESTART, pick_sample(), pick_sample());
    send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000);
    send_item(OP_SAMPLE, -16'sd1, 16'sd1);
    send_item(OP_SAMPLE, 16'sh8000, 16'sh7FFF);
  endtask

  // Zero seed keeps the register at zero; a full period of negative extremes
  // against chip -1 gives exactly +2^15, which must clip.
  task automatic test_zero_seed();
    settle();
    write_reg(REG_START_SEED, 16'h0000);
    write_reg(REG_FEEDBACK_MASK, 16'hFFFF);
    send_item(OP_RESTART, 16'sh7FFF, 16'sh7FFF);
    repeat (3) send_item(OP_SAMPLE, 16'sh8000, 16'sh8000);
  endtask

  // Zero mask: plain shift register. Also a write to the unused index.
  task automatic test_zero_mask();
    settle();
    write_reg(REG_FEEDBACK_MASK, 16'h0000);
    write_reg(REG_START_SEED, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(OP_RESTART, 16'sh8000, 16'sh8000);
    repeat (3) send_item(OP_SAMPLE, pick_sample(), pick_sample());
  endtask

  // Degree clamping at both ends and the largest legal degree.
  task automatic test_degree_limits();
    settle();
    write_reg(REG_CODE_DEGREE, 16'd0);
    write_reg(REG_FEEDBACK_MASK, 16'hB400);
    write_reg(REG_START_SEED, 16'hACE1);
    send_item(OP_RESTART, 16'sd0, 16'sd0);
    repeat (3) send_item(OP_SAMPLE, pick_sample(), pick_sample());
    settle();
    write_reg(REG_CODE_DEGREE, 16'd31);
    send_item(OP_RESTART, 16'sd0, 16'sd0);
    repeat (2) send_item(OP_SAMPLE, pick_sample(), pick_sample());
    settle();
    write_reg(REG_CODE_DEGREE, 16'd16);
    send_item(OP_RESTART, 16'sd0, 16'sd0);
    send_item(OP_SAMPLE, 16'sh7FFF, 16'sh8000);
  endtask

  // Phases of random config, mostly restart followed by random samples that need not fill
  // whole periods, with the odd restart breaking a period and phases that skip the restart.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned n;
    logic [CFG_DATA_BITS-1:0] val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        val = CFG_DATA_BITS'($urandom);
        val[DEG_BITS-1:0] = DEG_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8)
                                                                   : $urandom_range(2, 5));
        write_reg(REG_CODE_DEGREE, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          default: val = CFG_DATA_BITS'($urandom_range(1, 65535));
        endcase
        write_reg(REG_FEEDBACK_MASK, val);
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          2:       val = 16'h0001;
          default: val = CFG_DATA_BITS'($urandom);
        endcase
        write_reg(REG_START_SEED, val);
      end
      if ($urandom_range(0, 7) != 0) begin
        send_item(OP_RESTART, pick_sample(), pick_sample());
        sent++;
      end
      phase_len = $urandom_range(20, 60);
      for (n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 31) == 0) send_item(OP_RESTART, pick_sample(), pick_sample());
        else send_item(OP_SAMPLE, pick_sample(), pick_sample());
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_command  = OP_SAMPLE;
    in_sample_i = '0;
    in_sample_q = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_CODE_DEGREE;
    cfg_data    = '0;
    model_cfg   = '{code_degree: RST_CODE_DEGREE, feedback_mask: RST_FEEDBACK_MASK,
                    start_seed: RST_START_SEED};
    code_reg        = '0;
    held_chip       = 1'b0;
    chip_pos        = 0;
    sum_i           = 0;
    sum_q           = 0;
    trailing_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_restart();
    test_reset_code();
    test_zero_seed();
    test_zero_mask();
    test_degree_limits();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("pn_sequence_correlator_test: clean");
    end else begin
      $display("pn_sequence_correlator_test: errors");
    end
    $finish;
  end

  // Receiver backpressure: runs of no stall, random stall, or solid stall.
  initial begin
    stall_mode_t mode;
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 2));
      run  = $urandom_range(1, 60);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
          default:      out_stall <= 1'b1;
        endcase
      end
    end
  end

  // Result checker: every accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (corr_expected.size() == 0) begin
        $error("unexpected result: corr_i %0d corr_q %0d", out_corr_i, out_corr_q);
        mismatch_count++;
      end else begin
        corr_front = corr_expected.pop_front();
        if (out_corr_i !== corr_front.corr_i) begin
          $error("corr_i: expected %0d, actual %0d", corr_front.corr_i, out_corr_i);
          mismatch_count++;
        end
        if (out_corr_q !== corr_front.corr_q) begin
          $error("corr_q: expected %0d, actual %0d", corr_front.corr_q, out_corr_q);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("pn_sequence_correlator_test: errors");
        $finish;
      end
    end
  end

endmodule
